### rtl/iasu_pkg.sv
`default_nettype none

package iasu_pkg;

   // Shared arithmetic unit widths
   localparam int ACC_W  = 41;
   localparam int OPB_W  = 16;
   localparam int STEP_W = 6;

   localparam logic [STEP_W-1:0] MUL_STEPS = 6'd16;
   localparam logic [STEP_W-1:0] DIV_STEPS = 6'd41;

   typedef enum logic [1:0] {
      OP_MUL = 2'b01,
      OP_DIV = 2'b10
   } alu_op_type;

   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic [ACC_W-1:0] opa;
      logic [OPB_W-1:0] opb;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   typedef struct packed {
      logic init;
      logic push;
   } track_cmd_type;

   // Anneal phases as seen on the result channel
   localparam logic [3:0] PH_WAIT     = 4'd0;
   localparam logic [3:0] PH_START    = 4'd1;
   localparam logic [3:0] PH_HEAT     = 4'd2;
   localparam logic [3:0] PH_CALC     = 4'd3;
   localparam logic [3:0] PH_SAVE     = 4'd4;
   localparam logic [3:0] PH_WAITDROP = 4'd5;
   localparam logic [3:0] PH_DROP     = 4'd6;
   localparam logic [3:0] PH_PAUSE    = 4'd7;
   localparam logic [3:0] PH_ABORT    = 4'd8;

   // Button events
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   // Register map
   localparam int         CSR_ADDR_W    = 3;
   localparam logic       REG_DROP_TIME = 1'b0;
   localparam logic       REG_INTERVAL  = 1'b1;
   localparam logic [15:0] DROP_TIME_RESET = 16'd1000;
   localparam logic [9:0]  INTERVAL_RESET  = 10'd50;

   // 256*T*(312000-8T)/500000 reduces to 64*T*(39000-T)/15625
   localparam logic [16:0] ADVICE_PIVOT   = 17'd39000;
   localparam logic [15:0] ADVICE_DIVISOR = 16'd15625;

endpackage

`default_nettype wire

### rtl/iasu_alu.sv
`default_nettype none

module iasu_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  iasu_pkg::alu_cmd_type      cmd,
   output iasu_pkg::alu_stat_type     stat,
   output logic [iasu_pkg::ACC_W-1:0] result
);
   import iasu_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  opa_ff, opa_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic [OPB_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   logic [OPB_W:0]    trial;
   logic [ACC_W-1:0]  add_x;
   logic [ACC_W-1:0]  add_y;
   logic              add_cin;
   logic [ACC_W:0]    sum;
   logic              fits;

   // One adder: shift-add for multiply, trial subtract for divide
   always_comb begin
      trial = {rem_ff, acc_ff[ACC_W-1]};
      if (op_ff == OP_DIV) begin
         add_x   = ACC_W'(trial);
         add_y   = ~ACC_W'(opb_ff);
         add_cin = 1'b1;
      end else begin
         add_x   = {acc_ff[ACC_W-2:0], 1'b0};
         add_y   = opb_ff[OPB_W-1] ? opa_ff : '0;
         add_cin = 1'b0;
      end
      sum  = {1'b0, add_x} + {1'b0, add_y} + (ACC_W+1)'(add_cin);
      fits = sum[ACC_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         opa_in  = cmd.opa;
         opb_in  = cmd.opb;
         rem_in  = '0;
         if (cmd.op == OP_DIV) begin
            acc_in = cmd.opa;
            cnt_in = DIV_STEPS;
         end else begin
            acc_in = '0;
            cnt_in = MUL_STEPS;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            rem_in = fits ? sum[OPB_W-1:0] : trial[OPB_W-1:0];
            acc_in = {acc_ff[ACC_W-2:0], fits};
         end else begin
            acc_in = sum[ACC_W-1:0];
            opb_in = {opb_ff[OPB_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

`default_nettype wire

### rtl/iasu_track.sv
`default_nettype none

module iasu_track #(
   parameter int WINDOW_DEPTH = 5,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iasu_pkg::track_cmd_type cmd,
   input  logic [SAMPLE_BITS-1:0]  sample,
   input  logic [15:0]             elapsed_sat,
   output logic                    falling,
   output logic [15:0]             peak_time
);
   import iasu_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [FILL_W-1:0] FULL = FILL_W'(WINDOW_DEPTH);

   logic [SAMPLE_BITS-1:0] win_ff [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] shift_src [WINDOW_DEPTH];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0] peak_cur_ff, peak_cur_in;
   logic [15:0]            peak_time_ff, peak_time_in;
   logic                   full;
   logic [SAMPLE_BITS-1:0] oldest;

   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_src
      if (g < WINDOW_DEPTH - 1) begin : g_mid
         assign shift_src[g] = win_ff[g+1];
      end else begin : g_tail
         assign shift_src[g] = sample;
      end
   end

   assign full = (fill_ff == FULL);

   // Oldest entry as it stands after this push
   always_comb begin
      if (fill_ff == '0) begin
         oldest = sample;
      end else if (!full) begin
         oldest = win_ff[0];
      end else begin
         oldest = win_ff[1];
      end
   end

   assign falling = (sample < oldest);

   always_comb begin
      fill_in      = fill_ff;
      peak_cur_in  = peak_cur_ff;
      peak_time_in = peak_time_ff;
      if (cmd.init) begin
         fill_in      = FILL_W'(1);
         peak_cur_in  = sample;
         peak_time_in = '0;
      end else if (cmd.push) begin
         fill_in = full ? FULL : fill_ff + 1'b1;
         if (sample > peak_cur_ff) begin
            peak_cur_in  = sample;
            peak_time_in = elapsed_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (cmd.init) begin
            if (i == 0) begin
               win_ff[i] <= sample;
            end
         end else if (cmd.push) begin
            if (full) begin
               win_ff[i] <= shift_src[i];
            end else if (fill_ff == FILL_W'(i)) begin
               win_ff[i] <= sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         peak_cur_ff  <= '0;
         peak_time_ff <= '0;
      end else begin
         fill_ff      <= fill_in;
         peak_cur_ff  <= peak_cur_in;
         peak_time_ff <= peak_time_in;
      end
   end

   assign peak_time = peak_time_ff;

endmodule

`default_nettype wire

### rtl/induction_anneal_sequencer_unit.sv
// Sequence: a pass latches its transfer, evaluates it, then loads its result
// into the output register; a heating pass that checks the sample schedule adds
// one 16-step multiply, and the calculate pass a multiply, divide, multiply and
// divide, 1 bit a step. Throughput: one pass at a time; the next transfer is
// taken once the result is in the output register. Synchronous active-high
// reset sets phase 0 and resets counters, advice and configuration registers.
`default_nettype none

module induction_anneal_sequencer_unit #(
   parameter int WINDOW_DEPTH = 5,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [31:0]                     req_now_ms,
   input  logic [15:0]                     req_amps_sample,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_phase,
   output logic                            rsp_heater_on,
   output logic                            rsp_solenoid_on,
   output logic                            rsp_exit_to_menu,
   output logic signed [23:0]              rsp_last_advice,
   output logic signed [23:0]              rsp_mean_advice,
   output logic [15:0]                     rsp_cycles_done,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [iasu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import iasu_pkg::*;

   // Pass sequencer
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EVAL   = 8'b0000_0010,
      ST_HEAT   = 8'b0000_0100,
      ST_CALC_P = 8'b0000_1000,
      ST_CALC_R = 8'b0001_0000,
      ST_CALC_M = 8'b0010_0000,
      ST_CALC_D = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } seq_state_type;

   seq_state_type          seq_ff, seq_in;

   // Latched transfer
   logic [1:0]             mode_ff, mode_in;
   logic [31:0]            now_ff, now_in;
   logic [SAMPLE_BITS-1:0] amps_ff, amps_in;

   // Anneal state
   logic [3:0]             phase_ff, phase_in;
   logic [31:0]            run_start_ff, run_start_in;
   logic [15:0]            samples_ff, samples_in;
   logic signed [23:0]     advice_ff, advice_in;
   logic signed [23:0]     mean_ff, mean_in;
   logic [15:0]            cycles_ff, cycles_in;
   logic [31:0]            drop_start_ff, drop_start_in;
   logic                   exit_ff, exit_in;
   logic [31:0]            elapsed_ff, elapsed_in;
   logic                   neg_ff, neg_in;

   // Configuration
   logic [15:0]            drop_time_ff;
   logic [9:0]             interval_ff;
   logic                   csr_write;
   logic                   csr_index;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             rsp_phase_ff;
   logic                   rsp_exit_ff;
   logic signed [23:0]     rsp_advice_ff;
   logic signed [23:0]     rsp_mean_ff;
   logic [15:0]            rsp_cycles_ff;
   logic                   rsp_load;

   // Shared unit and sample tracker
   alu_cmd_type            alu_cmd;
   alu_stat_type           alu_stat;
   logic [ACC_W-1:0]       alu_result;
   track_cmd_type          track_cmd;
   logic                   track_falling;
   logic [15:0]            peak_time;
   logic [15:0]            elapsed_sat;

   // Datapath helpers
   logic                   active;
   logic                   is_start;
   logic                   is_stop;
   logic [9:0]             interval_eff;
   logic [16:0]            pivot_diff;
   logic [15:0]            pivot_mag;
   logic [23:0]            mean_mag;
   logic signed [23:0]     quot_signed;
   logic signed [ACC_W-1:0] prod_signed;
   logic signed [ACC_W-1:0] sum_signed;
   logic [ACC_W-1:0]       sum_mag;

   iasu_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .stat   (alu_stat),
      .result (alu_result)
   );

   iasu_track #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .cmd         (track_cmd),
      .sample      (amps_ff),
      .elapsed_sat (elapsed_sat),
      .falling     (track_falling),
      .peak_time   (peak_time)
   );

   // Phases 1, 2, 3, 4 and 6 are running: stop aborts, start is ignored
   always_comb begin
      active   = phase_ff inside {PH_START, PH_HEAT, PH_CALC, PH_SAVE, PH_DROP};
      is_start = (mode_ff == MODE_START);
      is_stop  = (mode_ff == MODE_STOP);
   end

   // Zero interval acts as 1 ms
   assign interval_eff = (interval_ff == '0) ? 10'd1 : interval_ff;
   assign elapsed_sat  = (elapsed_ff > 32'h0000_FFFF) ? 16'hFFFF : elapsed_ff[15:0];

   // Advice term: 64*T*(39000-T)/15625, carried as sign and magnitude
   always_comb begin
      pivot_diff  = ADVICE_PIVOT - {1'b0, peak_time};
      pivot_mag   = pivot_diff[16] ? 16'(-pivot_diff) : pivot_diff[15:0];
      mean_mag    = mean_ff[23] ? 24'(-mean_ff) : 24'(mean_ff);
      quot_signed = neg_ff ? -$signed(alu_result[23:0]) : $signed(alu_result[23:0]);
      prod_signed = neg_ff ? -$signed(alu_result) : $signed(alu_result);
      sum_signed  = prod_signed + {{(ACC_W-24){advice_ff[23]}}, advice_ff};
      sum_mag     = sum_signed[ACC_W-1] ? ACC_W'(-sum_signed) : ACC_W'(sum_signed);
   end

   always_comb begin
      seq_in        = seq_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      amps_in       = amps_ff;
      phase_in      = phase_ff;
      run_start_in  = run_start_ff;
      samples_in    = samples_ff;
      advice_in     = advice_ff;
      mean_in       = mean_ff;
      cycles_in     = cycles_ff;
      drop_start_in = drop_start_ff;
      exit_in       = exit_ff;
      elapsed_in    = elapsed_ff;
      neg_in        = neg_ff;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = OP_MUL;
      alu_cmd.opa   = '0;
      alu_cmd.opb   = '0;
      track_cmd     = '0;
      rsp_load      = 1'b0;

      case (seq_ff)
         ST_IDLE: begin
            // Latch the transfer and evaluate it next cycle
            if (req_valid) begin
               mode_in = req_mode;
               now_in  = req_now_ms;
               amps_in = req_amps_sample[SAMPLE_BITS-1:0];
               seq_in  = ST_EVAL;
            end
         end

         ST_EVAL: begin
            exit_in = 1'b0;
            seq_in  = ST_DONE;
            if (active && is_stop) begin
               // Abort: heater and solenoid drop with the phase
               phase_in = PH_ABORT;
            end else begin
               case (phase_ff)
                  PH_START: begin
                     // First sample opens the window and sets the peak
                     track_cmd.init = 1'b1;
                     samples_in     = 16'd1;
                     cycles_in      = (cycles_ff != 16'hFFFF) ? cycles_ff + 1'b1 : cycles_ff;
                     run_start_in   = now_ff;
                     phase_in       = PH_HEAT;
                  end
                  PH_HEAT: begin
                     // Sample is due when elapsed >= (samples+1)*interval
                     elapsed_in = now_ff - run_start_ff;
                     if (samples_ff != 16'hFFFF) begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = OP_MUL;
                        alu_cmd.opa   = ACC_W'(interval_eff);
                        alu_cmd.opb   = samples_ff + 1'b1;
                        seq_in        = ST_HEAT;
                     end
                  end
                  PH_CALC: begin
                     alu_cmd.start = 1'b1;
                     alu_cmd.op    = OP_MUL;
                     alu_cmd.opa   = ACC_W'(peak_time);
                     alu_cmd.opb   = pivot_mag;
                     neg_in        = pivot_diff[16];
                     seq_in        = ST_CALC_P;
                  end
                  PH_SAVE: begin
                     phase_in = PH_WAITDROP;
                  end
                  PH_WAITDROP: begin
                     if (is_stop || is_start) begin
                        drop_start_in = now_ff;
                        phase_in      = PH_DROP;
                     end
                  end
                  PH_DROP: begin
                     if ((now_ff - drop_start_ff) >= {16'd0, drop_time_ff}) begin
                        phase_in = PH_PAUSE;
                     end
                  end
                  PH_PAUSE, PH_ABORT: begin
                     if (is_stop) begin
                        // End the series
                        cycles_in    = '0;
                        advice_in    = '0;
                        mean_in      = '0;
                        run_start_in = '0;
                        samples_in   = '0;
                        phase_in     = PH_WAIT;
                     end else if (is_start) begin
                        phase_in = PH_WAIT;
                     end
                  end
                  default: begin
                     // Waiting for start; unused codes behave the same
                     phase_in = PH_WAIT;
                     if (is_stop) begin
                        exit_in = 1'b1;
                     end else if (is_start) begin
                        phase_in = PH_START;
                     end
                  end
               endcase
            end
         end

         ST_HEAT: begin
            if (alu_stat.done) begin
               if (elapsed_ff >= alu_result[31:0]) begin
                  samples_in     = samples_ff + 1'b1;
                  track_cmd.push = 1'b1;
                  // Newest below oldest: the peak has passed
                  if (track_falling) begin
                     phase_in = PH_CALC;
                  end
               end
               seq_in = ST_DONE;
            end
         end

         ST_CALC_P: begin
            if (alu_stat.done) begin
               // Scale the product by 64 and divide by 15625
               alu_cmd.start = 1'b1;
               alu_cmd.op    = OP_DIV;
               alu_cmd.opa   = ACC_W'({alu_result[31:0], 6'b00_0000});
               alu_cmd.opb   = ADVICE_DIVISOR;
               seq_in        = ST_CALC_R;
            end
         end

         ST_CALC_R: begin
            if (alu_stat.done) begin
               advice_in = quot_signed;
               if (cycles_ff == '0) begin
                  mean_in  = quot_signed;
                  phase_in = PH_SAVE;
                  seq_in   = ST_DONE;
               end else begin
                  // mean*(n-1), then add the new advice and divide by n
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = OP_MUL;
                  alu_cmd.opa   = ACC_W'(mean_mag);
                  alu_cmd.opb   = cycles_ff - 1'b1;
                  neg_in        = mean_ff[23];
                  seq_in        = ST_CALC_M;
               end
            end
         end

         ST_CALC_M: begin
            if (alu_stat.done) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = OP_DIV;
               alu_cmd.opa   = sum_mag;
               alu_cmd.opb   = cycles_ff;
               neg_in        = sum_signed[ACC_W-1];
               seq_in        = ST_CALC_D;
            end
         end

         ST_CALC_D: begin
            if (alu_stat.done) begin
               mean_in  = quot_signed;
               phase_in = PH_SAVE;
               seq_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               seq_in   = ST_IDLE;
            end
         end

         default: begin
            seq_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= ST_IDLE;
         phase_ff      <= PH_WAIT;
         run_start_ff  <= '0;
         samples_ff    <= '0;
         advice_ff     <= '0;
         mean_ff       <= '0;
         cycles_ff     <= '0;
         drop_start_ff <= '0;
         exit_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         run_start_ff  <= run_start_in;
         samples_ff    <= samples_in;
         advice_ff     <= advice_in;
         mean_ff       <= mean_in;
         cycles_ff     <= cycles_in;
         drop_start_ff <= drop_start_in;
         exit_ff       <= exit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      now_ff     <= now_in;
      amps_ff    <= amps_in;
      elapsed_ff <= elapsed_in;
      neg_ff     <= neg_in;
      if (rsp_load) begin
         rsp_phase_ff  <= phase_ff;
         rsp_exit_ff   <= exit_ff;
         rsp_advice_ff <= advice_ff;
         rsp_mean_ff   <= mean_ff;
         rsp_cycles_ff <= cycles_ff;
      end
   end

   // Register port: word index from paddr[2]
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_time_ff <= DROP_TIME_RESET;
         interval_ff  <= INTERVAL_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_INTERVAL) begin
            interval_ff <= csr_pwdata[9:0];
         end else begin
            drop_time_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_index == REG_DROP_TIME) ? {16'd0, drop_time_ff}
                                                    : {22'd0, interval_ff};
   assign csr_pready = 1'b1;

   assign req_ready        = (seq_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_heater_on    = (rsp_phase_ff == PH_HEAT);
   assign rsp_solenoid_on  = (rsp_phase_ff == PH_DROP);
   assign rsp_exit_to_menu = rsp_exit_ff;
   assign rsp_last_advice  = rsp_advice_ff;
   assign rsp_mean_advice  = rsp_mean_ff;
   assign rsp_cycles_done  = rsp_cycles_ff;

endmodule

`default_nettype wire

### rtl/iasu_checker.sv
`default_nettype none

module iasu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_phase,
   input logic       rsp_heater_on,
   input logic       rsp_solenoid_on,
   input logic       rsp_exit_to_menu
);
   import iasu_pkg::*;

   // Drives follow the phase they belong to
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heater_on == (rsp_phase == PH_HEAT)) &&
                    (rsp_solenoid_on == (rsp_phase == PH_DROP)))
      else $error("heater or solenoid drive disagrees with phase");

   // Exit pulse only while waiting for start
   a_exit_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exit_to_menu |-> rsp_phase == PH_WAIT)
      else $error("exit pulse outside the wait phase");

   // One pass in flight at a time
   a_one_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transfer taken while a pass is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase))
      else $error("stalled result dropped or changed");

endmodule

bind induction_anneal_sequencer_unit iasu_checker u_iasu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_phase        (rsp_phase),
   .rsp_heater_on    (rsp_heater_on),
   .rsp_solenoid_on  (rsp_solenoid_on),
   .rsp_exit_to_menu (rsp_exit_to_menu)
);

`default_nettype wire
